// File: sv/ais_pkg.sv
// Package for the ascending integer sorter: depth, widths and transfer structs.
// Depends on nothing; every other file imports it.
package ais_pkg;

  localparam int DEPTH   = 16;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] sorted_value;
    logic                    final_res;
    logic                    overflow;
  } result_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctl_t;

endpackage

// File: sv/ais_cell.sv
// One cell of the sorting chain: holds one value, takes part in insertion and
// in the left shift that drains the chain. Depends on ais_pkg.
module ais_cell
  import ais_pkg::*;
(
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic signed [VAL_W-1:0] x,
  input  logic                    empty,
  input  logic signed [VAL_W-1:0] left_val,
  input  logic                    left_less,
  input  logic signed [VAL_W-1:0] right_val,
  output logic signed [VAL_W-1:0] val,
  output logic                    less
);

  // Unused slots sit above all held values.
  assign less = empty || (x < val);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      val <= right_val;
    end else if (ctl.insert && less) begin
      val <= left_less ? left_val : x;
    end
  end

endmodule

// File: sv/ascending_integer_sorter.sv
// Ascending signed sorter built as an insertion chain of DEPTH cells.
// Load: one value per cycle, busy low; a value enters its sorted slot at once.
// Drain: the transfer flagged last starts one result per held value, one per
// cycle from the head cell; busy is high exactly while these results come out.
// The first result comes in the cycle after the last transfer. No output stall.
// Reset (rst, synchronous): count and overflow cleared, back to loading.
module ascending_integer_sorter
  import ais_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    strobe,
  output result_t result
);

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;   // held values; during drain, values left
  logic              dropped, dropped_next;

  logic              accept;
  logic              room;
  cell_ctl_t         ctl;

  logic signed [VAL_W-1:0] cell_val  [DEPTH];
  logic                    cell_less [DEPTH];

  assign busy   = (state == ST_DRAIN);
  assign accept = start && !busy;
  assign room   = (count < CNT_W'(DEPTH));

  // Full store: the newest value is dropped, held ones stay.
  assign ctl.insert = accept && room;
  assign ctl.shift  = busy;

  // Head cell always holds the smallest remaining value.
  assign strobe              = busy;
  assign result.sorted_value = cell_val[0];
  assign result.final_res    = (count == CNT_W'(1));
  assign result.overflow     = dropped;

  for (genvar i = 0; i < DEPTH; i++) begin : g_chain
    logic signed [VAL_W-1:0] lv, rv;
    logic                    ll;

    if (i == 0) begin : g_head
      assign lv = item.value;
      assign ll = 1'b0;
    end else begin : g_body
      assign lv = cell_val[i-1];
      assign ll = cell_less[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rv = item.value;   // don't-care: slot goes out of range
    end else begin : g_mid
      assign rv = cell_val[i+1];
    end

    ais_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .x         (item.value),
      .empty     (CNT_W'(i) >= count),
      .left_val  (lv),
      .left_less (ll),
      .right_val (rv),
      .val       (cell_val[i]),
      .less      (cell_less[i])
    );
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    dropped_next = dropped;
    unique case (state)
      ST_LOAD: begin
        if (accept) begin
          if (room) begin
            count_next = count + CNT_W'(1);
          end else begin
            dropped_next = 1'b1;
          end
          if (item.last) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        count_next = count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          state_next   = ST_LOAD;
          dropped_next = 1'b0;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      dropped <= dropped_next;
    end
  end

endmodule

// File: sv/ais_checker.sv
// Port-level checks for the ascending integer sorter, bound to the top level.
// Depends on ais_pkg.
module ais_checker
  import ais_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input item_t   item,
  input logic    busy,
  input logic    strobe,
  input result_t result
);

  a_last_starts_drain: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.last) |=> strobe)
    else $error("no result after last transfer");

  a_drain_continues: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.final_res) |=> strobe)
    else $error("drain stopped before final result");

  a_final_ends_drain: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.final_res) |=> !busy)
    else $error("still busy after final result");

  a_busy_only_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && item.last))
    else $error("drain began without a last transfer");

  a_overflow_steady: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.final_res) |=> $stable(result.overflow))
    else $error("overflow changed within one set");

endmodule

bind ascending_integer_sorter ais_checker u_ais_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .item   (item),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);

// File: tb/sv/tb_ascending_integer_sorter.sv
// Testbench for ascending_integer_sorter: sends sets of signed values with random
// gaps, predicts the sorted drain of each set and checks every result transfer.
// Depends on ais_pkg and the sorter RTL.
`timescale 1ns / 100ps

module tb_ascending_integer_sorter;
  import ais_pkg::*;

  logic    clk;
  logic    rst;
  logic    start;
  item_t   item;
  logic    busy;
  logic    strobe;
  result_t result;

  ascending_integer_sorter dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  // 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Predictor state: values held for the open set, in arrival order.
  logic signed [VAL_W-1:0] held_vals [DEPTH];
  int unsigned             held_n;
  logic                    set_dropped;

  // Sorted results still owed by the block, oldest first.
  result_t sorted_q [$];

  int unsigned gap_max;        // sender gap limit per transfer, 0 = back to back
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned sets_closed;
  int unsigned overflow_sets;
  int unsigned results_seen;

  // Predict one accepted transfer; a transfer flagged last queues the sorted set.
  task automatic predict_transfer(input item_t it);
    logic signed [VAL_W-1:0] tmp [DEPTH];
    logic signed [VAL_W-1:0] key;
    result_t                 r;
    int                      i;
    int                      j;
    items_sent++;
    if (held_n < DEPTH) begin
      held_vals[held_n] = it.value;
      held_n++;
    end else begin
      set_dropped = 1'b1;
    end
    if (it.last) begin
      // insertion sort, signed compare
      for (i = 0; i < int'(held_n); i++) begin
        key = held_vals[i];
        j = i - 1;
        while (j >= 0 && tmp[j] > key) begin
          tmp[j+1] = tmp[j];
          j--;
        end
        tmp[j+1] = key;
      end
      for (i = 0; i < int'(held_n); i++) begin
        r.sorted_value = tmp[i];
        r.final_res    = (i == int'(held_n) - 1);
        r.overflow     = set_dropped;
        sorted_q.push_back(r);
      end
      sets_closed++;
      if (set_dropped) overflow_sets++;
      held_n      = 0;
      set_dropped = 1'b0;
    end
  endtask

  // Send one transfer after a random gap. Start stays high on return so a
  // zero-gap follower goes out on the very next edge.
  task automatic send_item(input logic signed [VAL_W-1:0] v, input logic l);
    int unsigned gap;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    item.value <= v;
    item.last  <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_transfer('{value: v, last: l});
  endtask

  // Hold off the sender until every owed result has come out.
  task automatic wait_drained(input int unsigned limit);
    int unsigned n;
    n = 0;
    start <= 1'b0;
    @(posedge clk);
    while (sorted_q.size() != 0 && n < limit) begin
      @(posedge clk);
      n++;
    end
  endtask

  // Mix of full-range, clustered (many duplicates), extreme and sign-bit-plus-16-bit values.
  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 4))
      0, 1: v = $urandom;
      2: v = $signed($urandom_range(0, 8)) - 4;
      3: begin
        case ($urandom_range(0, 3))
          0: v = {1'b1, {(VAL_W-1){1'b0}}};
          1: v = {1'b0, {(VAL_W-1){1'b1}}};
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 15'h0, 16'($urandom)};
    endcase
    return v;
  endfunction

  // One well-formed set; now and then longer than the store holds.
  task automatic send_random_set();
    int unsigned len;
    int unsigned k;
    if ($urandom_range(0, 9) == 0)
      len = $urandom_range(DEPTH + 1, DEPTH + 5);
    else if ($urandom_range(0, 3) == 0)
      len = $urandom_range(1, 2);
    else
      len = $urandom_range(1, DEPTH);
    for (k = 1; k <= len; k++)
      send_item(pick_value(), k == len);
  endtask

  // Result checker: the receiver never stalls, so every strobe is a transfer.
  always @(posedge clk) begin
    result_t want;
    if (!rst && strobe) begin
      results_seen++;
      if (sorted_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result transfer: value %0d final %0b overflow %0b",
                 $time, result.sorted_value, result.final_res, result.overflow);
      end else begin
        want = sorted_q.pop_front();
        if (result.sorted_value !== want.sorted_value) begin
          fail_count++;
          $display("%0t: sorted_value expected %0d actual %0d",
                   $time, want.sorted_value, result.sorted_value);
        end
        if (result.final_res !== want.final_res) begin
          fail_count++;
          $display("%0t: final_res expected %0b actual %0b",
                   $time, want.final_res, result.final_res);
        end
        if (result.overflow !== want.overflow) begin
          fail_count++;
          $display("%0t: overflow expected %0b actual %0b",
                   $time, want.overflow, result.overflow);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Single-value set at the negative extreme, then a mixed set with both
  // extremes, zero, -1, +1 and a duplicate maximum.
  task automatic test_corner_values();
    gap_max = 7;
    send_item({1'b1, {(VAL_W-1){1'b0}}}, 1'b1);
    send_item({1'b0, {(VAL_W-1){1'b1}}}, 1'b0);
    send_item({1'b1, {(VAL_W-1){1'b0}}}, 1'b0);
    send_item('0, 1'b0);
    send_item('1, 1'b0);
    send_item(32'sd1, 1'b0);
    send_item({1'b0, {(VAL_W-1){1'b1}}}, 1'b1);
  endtask

  // Store overrun: DEPTH+2 values, reverse ordered; the last two, the flagged last one among them, dropped.
  task automatic test_overflow();
    int k;
    gap_max = 3;
    for (k = 0; k < DEPTH + 2; k++)
      send_item(32'sd1000 - 32'(k * 97) - 32'sd700, k == DEPTH + 1);
  endtask

  // No sender gaps: the next set's first transfer waits only on busy.
  task automatic test_back_to_back();
    gap_max = 0;
    while (items_sent < 85) send_random_set();
  endtask

  // Random gaps on every transfer; occasional full drains.
  task automatic test_random_gaps();
    gap_max = 7;
    while (items_sent < 245) begin
      send_random_set();
      if ($urandom_range(0, 5) == 0) wait_drained(1000);
    end
  endtask

  // Sender stops until the previous set is fully out, then sends a full set.
  task automatic test_pause_until_drained();
    int k;
    gap_max = 2;
    wait_drained(1000);
    for (k = 0; k < DEPTH; k++)
      send_item(pick_value(), k == DEPTH - 1);
  endtask

  initial begin
    int unsigned n;
    fail_count    = 0;
    items_sent    = 0;
    sets_closed   = 0;
    overflow_sets = 0;
    results_seen  = 0;
    held_n        = 0;
    set_dropped   = 1'b0;
    gap_max       = 0;
    rst   <= 1'b1;
    start <= 1'b0;
    item  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_values();
    test_overflow();
    test_back_to_back();
    test_random_gaps();
    test_pause_until_drained();

    // Drain: wait for owed results, then watch for stray strobes.
    start <= 1'b0;
    n = 0;
    while (sorted_q.size() != 0 && n < 2000) begin
      @(posedge clk);
      n++;
    end
    repeat (DEPTH + 4) @(posedge clk);
    if (sorted_q.size() != 0) begin
      fail_count++;
      $display("%0t: %0d sorted results never arrived, next expected %0d",
               $time, sorted_q.size(), sorted_q[0].sorted_value);
    end

    $display("Sent %0d values in %0d sets (%0d overrunning the store).",
             items_sent, sets_closed, overflow_sets);
    $display("Checked %0d sorted result transfers, %0d mismatches.",
             results_seen, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #400000;
    $display("%0t: timeout", $time);
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: sim.f
sv/ais_pkg.sv
sv/ais_cell.sv
sv/ascending_integer_sorter.sv
sv/ais_checker.sv
tb/sv/tb_ascending_integer_sorter.sv
